// ===== rtl/krsel_pkg.sv =====
// Shared types, codes and helpers for the k-th remaining index select block.
// No dependencies; every other file except krsel_bitmap_ram imports this package.
`timescale 1ns / 1ps

package krsel_pkg;

  localparam int VAL_W  = 16;
  localparam int CNT_W  = 13;
  localparam int WORD_W = 64;

  // Operation codes carried in the mode field
  localparam logic [1:0] MODE_CHOOSE  = 2'd0;
  localparam logic [1:0] MODE_REMOVE  = 2'd1;
  localparam logic [1:0] MODE_REBUILD = 2'd2;

  // Configuration register indexes
  localparam logic REG_FIRST = 1'b0;
  localparam logic REG_LAST  = 1'b1;

  typedef struct packed {
    logic [1:0]       mode;
    logic [VAL_W-1:0] position;
    logic [VAL_W-1:0] remove_value;
  } krsel_in_t;

  typedef struct packed {
    logic [VAL_W-1:0] chosen_value;
    logic             chosen_valid;
    logic [CNT_W-1:0] remaining_count;
    logic [CNT_W-1:0] pseudo_count;
  } krsel_out_t;

  typedef struct packed {
    logic [VAL_W-1:0] first_value;
    logic [VAL_W-1:0] last_value;
  } krsel_cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REBUILD,
    ST_SCAN,
    ST_BYTE,
    ST_RM_CHK,
    ST_DONE
  } krsel_state_t;

  // Bit index of the k-th set bit in a byte, k counted from 1.
  function automatic logic [2:0] kth_in_byte(input logic [7:0] v, input logic [3:0] k);
    logic [3:0] c;
    logic [2:0] idx;
    c   = 4'd0;
    idx = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (v[i] && (c + 4'd1 == k)) idx = 3'(i);
      c = c + {3'b000, v[i]};
    end
    return idx;
  endfunction

endpackage

// ===== rtl/krsel_bitmap_ram.sv =====
// Presence bitmap storage: one write port, one registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module krsel_bitmap_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int WIDTH = 64
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/krsel_pop_unit.sv =====
// Shared popcount and rank compare: counts a 64-bit vector and tests it against k.
// Depends on krsel_pkg.
`timescale 1ns / 1ps

module krsel_pop_unit
  import krsel_pkg::*;
#(
  parameter int KW = 13
) (
  input  logic [WORD_W-1:0] vec,
  input  logic [KW-1:0]     k,
  output logic              k_gt,
  output logic [KW-1:0]     k_less
);

  localparam int PW = (KW > 7) ? KW : 7;

  logic [6:0] cnt;

  always_comb begin
    cnt = 7'd0;
    for (int i = 0; i < WORD_W; i++) cnt = cnt + {6'd0, vec[i]};
  end

  assign k_gt   = PW'(k) > PW'(cnt);
  // only used when k_gt, so the difference fits in KW bits
  assign k_less = KW'(PW'(k) - PW'(cnt));

endmodule

// ===== rtl/krsel_seq.sv =====
// Sequencer and datapath: rebuild sweep, word/byte rank scan, remove, result register.
// Depends on krsel_pkg, krsel_bitmap_ram and krsel_pop_unit.
`timescale 1ns / 1ps

module krsel_seq
  import krsel_pkg::*;
#(
  parameter int CAPACITY = 4096
) (
  input  logic       clk,
  input  logic       rst_n,
  input  krsel_cfg_t cfg,
  input  logic       in_valid,
  output logic       in_ready,
  input  krsel_in_t  in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output krsel_out_t out_data
);

  localparam int WORDS = (CAPACITY + WORD_W - 1) / WORD_W;
  localparam int WW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int CW    = $clog2(CAPACITY + 1);
  localparam logic [16:0] CAP17   = 17'(CAPACITY);
  localparam logic [WW-1:0] LAST_W = WW'(WORDS - 1);

  krsel_state_t state_r, state_nxt;
  logic [CW-1:0]     k_r, k_nxt;
  logic [WW-1:0]     w_r, w_nxt;
  logic [2:0]        j_r, j_nxt;
  logic [5:0]        bit_r, bit_nxt;
  logic [WORD_W-1:0] word_r, word_nxt;
  logic [16:0]       rem_r, rem_nxt;
  logic [CW-1:0]     live_r, live_nxt;
  logic [CW-1:0]     pseudo_r, pseudo_nxt;
  logic [VAL_W-1:0]  base_r, base_nxt;
  logic              built_r, built_nxt;
  logic [VAL_W-1:0]  cv_r, cv_nxt;
  logic              cval_r, cval_nxt;
  logic              out_valid_r, out_valid_nxt;
  krsel_out_t        out_data_r, out_data_nxt;

  logic              wr_en;
  logic [WW-1:0]     wr_addr, rd_addr;
  logic [WORD_W-1:0] wr_data, rd_data;

  logic [WORD_W-1:0] pop_vec;
  logic              pop_gt;
  logic [CW-1:0]     pop_less;

  logic [16:0]       n_raw, n_clip, diff;
  logic [7:0]        cur_byte;
  logic [2:0]        bsel;
  logic [16:0]       off;
  logic [CW-1:0]     pseudo_dec;

  krsel_bitmap_ram #(
    .DEPTH(WORDS),
    .AW   (WW),
    .WIDTH(WORD_W)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  krsel_pop_unit #(
    .KW(CW)
  ) u_pop (
    .vec   (pop_vec),
    .k     (k_r),
    .k_gt  (pop_gt),
    .k_less(pop_less)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    n_raw = (cfg.last_value >= cfg.first_value)
          ? (17'(cfg.last_value) - 17'(cfg.first_value) + 17'd1) : 17'd0;
    n_clip = (n_raw > CAP17) ? CAP17 : n_raw;
    diff   = {1'b0, in_data.remove_value} - {1'b0, base_r};
    cur_byte = word_r[j_r*8 +: 8];
    bsel     = kth_in_byte(cur_byte, 4'(k_r));
    off      = 17'({w_r, j_r, bsel});
    pseudo_dec = (pseudo_r != '0) ? pseudo_r - CW'(1) : pseudo_r;
  end

  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    w_nxt         = w_r;
    j_nxt         = j_r;
    bit_nxt       = bit_r;
    word_nxt      = word_r;
    rem_nxt       = rem_r;
    live_nxt      = live_r;
    pseudo_nxt    = pseudo_r;
    base_nxt      = base_r;
    built_nxt     = built_r;
    cv_nxt        = cv_r;
    cval_nxt      = cval_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    wr_en         = 1'b0;
    wr_addr       = w_r;
    wr_data       = rd_data;
    rd_addr       = w_r;
    pop_vec       = rd_data;

    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cv_nxt   = '0;
          cval_nxt = 1'b0;
          case (in_data.mode)
            MODE_CHOOSE: begin
              if ((in_data.position != '0) && (17'(in_data.position) <= 17'(live_r))) begin
                k_nxt     = CW'(in_data.position);
                w_nxt     = '0;
                rd_addr   = '0;
                state_nxt = ST_SCAN;
              end else begin
                state_nxt = ST_DONE;
              end
            end
            MODE_REMOVE: begin
              pseudo_nxt = pseudo_dec;
              if (built_r && !diff[16] && (diff < CAP17)) begin
                w_nxt     = WW'(diff >> 6);
                rd_addr   = WW'(diff >> 6);
                bit_nxt   = diff[5:0];
                state_nxt = ST_RM_CHK;
              end else begin
                state_nxt = ST_DONE;
              end
            end
            MODE_REBUILD: begin
              rem_nxt    = n_clip;
              w_nxt      = '0;
              base_nxt   = cfg.first_value;
              live_nxt   = CW'(n_clip);
              pseudo_nxt = CW'(n_clip);
              built_nxt  = 1'b1;
              state_nxt  = ST_REBUILD;
            end
            default: state_nxt = ST_DONE;
          endcase
        end
      end

      ST_REBUILD: begin
        // one word per cycle: full, partial or empty from the remaining fill
        wr_en   = 1'b1;
        wr_addr = w_r;
        if (rem_r >= 17'd64) begin
          wr_data = '1;
          rem_nxt = rem_r - 17'd64;
        end else begin
          wr_data = ~({WORD_W{1'b1}} << rem_r[5:0]);
          rem_nxt = '0;
        end
        if (w_r == LAST_W) state_nxt = ST_DONE;
        else w_nxt = w_r + WW'(1);
      end

      ST_SCAN: begin
        // rd_data holds word w_r; prefetch the next word meanwhile
        rd_addr = (w_r == LAST_W) ? w_r : w_r + WW'(1);
        pop_vec = rd_data;
        if (pop_gt) begin
          k_nxt = pop_less;
          w_nxt = w_r + WW'(1);
        end else begin
          word_nxt  = rd_data;
          j_nxt     = 3'd0;
          state_nxt = ST_BYTE;
        end
      end

      ST_BYTE: begin
        pop_vec = {{(WORD_W-8){1'b0}}, cur_byte};
        if (pop_gt) begin
          k_nxt = pop_less;
          j_nxt = j_r + 3'd1;
        end else begin
          wr_en      = 1'b1;
          wr_addr    = w_r;
          wr_data    = word_r & ~({{(WORD_W-1){1'b0}}, 1'b1} << {j_r, bsel});
          cv_nxt     = 16'(base_r + 16'(off));
          cval_nxt   = 1'b1;
          live_nxt   = live_r - CW'(1);
          pseudo_nxt = pseudo_dec;
          state_nxt  = ST_DONE;
        end
      end

      ST_RM_CHK: begin
        if (rd_data[bit_r]) begin
          wr_en    = 1'b1;
          wr_addr  = w_r;
          wr_data  = rd_data & ~({{(WORD_W-1){1'b0}}, 1'b1} << bit_r);
          live_nxt = live_r - CW'(1);
        end
        state_nxt = ST_DONE;
      end

      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_data_nxt.chosen_value    = cv_r;
          out_data_nxt.chosen_valid    = cval_r;
          out_data_nxt.remaining_count = CNT_W'(live_r);
          out_data_nxt.pseudo_count    = CNT_W'(pseudo_r);
          out_valid_nxt                = 1'b1;
          state_nxt                    = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      live_r      <= '0;
      pseudo_r    <= '0;
      base_r      <= '0;
      built_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      live_r      <= live_nxt;
      pseudo_r    <= pseudo_nxt;
      base_r      <= base_nxt;
      built_r     <= built_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r        <= k_nxt;
    w_r        <= w_nxt;
    j_r        <= j_nxt;
    bit_r      <= bit_nxt;
    word_r     <= word_nxt;
    rem_r      <= rem_nxt;
    cv_r       <= cv_nxt;
    cval_r     <= cval_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ===== rtl/kth_remaining_index_select_core.sv =====
// Top level: configuration register file on the APB-style port, and the sequencer.
// Depends on krsel_pkg and krsel_seq.
`timescale 1ns / 1ps

// Keeps a set of integers as a presence bitmap of CAPACITY bits, stored as 64-bit
// words in a memory with one write port and one registered read port, and handled
// one item at a time; in_ready is high only between items. Choose by position
// scans words, then bytes of the word holding the chosen entry, since one shared
// popcount unit ranks one memory word, then one byte, per cycle; it then clears
// the entry and registers the result. Remove by value inside the bitmap window
// reads the word, clears the bit if set, then registers the result; a remove
// outside the window or before the first rebuild, an invalid position or the
// unused mode goes straight to the result register, and rebuild first writes
// every word in its sweep. A result still held back by out_ready adds its stall.
// Until the first rebuild after reset the set reads as empty, so no clearing pass
// is needed. Registers: first_value at byte 0, last_value at byte 4, to be written
// only when idle; the block itself does not enforce this.
module kth_remaining_index_select_core
  import krsel_pkg::*;
#(
  parameter int CAPACITY = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  krsel_in_t   in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output krsel_out_t  out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  krsel_cfg_t cfg_r, cfg_nxt;
  logic       wr_stb;

  assign pready = 1'b1;
  assign wr_stb = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_stb) begin
      case (paddr[2])
        REG_FIRST: cfg_nxt.first_value = pwdata[VAL_W-1:0];
        REG_LAST:  cfg_nxt.last_value  = pwdata[VAL_W-1:0];
        default:   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_FIRST: prdata = {16'd0, cfg_r.first_value};
      REG_LAST:  prdata = {16'd0, cfg_r.last_value};
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.first_value <= 16'd1;
      cfg_r.last_value  <= 16'd0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  krsel_seq #(
    .CAPACITY(CAPACITY)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

// ===== dv/testbench.sv =====
// Testbench for kth_remaining_index_select_core: directed and random items,
// APB register writes between phases, and a scoreboard that predicts every result.
// Depends on krsel_pkg and the RTL under rtl/.
`timescale 1ns / 1ps

import krsel_pkg::*;

// Tracks the integer set and both counts, and holds the results still due from the block.
class index_set_scoreboard #(int CAP = 4096);
  bit [CAP-1:0] present;
  int unsigned live;
  int unsigned pseudo;
  int unsigned built;
  bit [15:0] base;
  bit [15:0] first_val;
  bit [15:0] last_val;
  krsel_out_t pending_results[$];
  int unsigned errors;

  function new();
    present = '0;
    live = 0;
    pseudo = 0;
    built = 0;
    base = '0;
    first_val = 16'd1;
    last_val = '0;
    errors = 0;
  endfunction

  function void write_reg(logic idx, bit [15:0] v);
    if (idx == REG_FIRST) first_val = v;
    else last_val = v;
  endfunction

  // Applies one accepted input transfer to the set and queues the result it causes.
  function void note_input(krsel_in_t it);
    krsel_out_t res;
    int unsigned off;
    int unsigned k;
    int unsigned n;
    res = '0;
    off = 0;
    case (it.mode)
      MODE_CHOOSE: begin
        if (it.position >= 1 && it.position <= live) begin
          k = it.position;
          for (int i = 0; i < CAP; i++) begin
            if (present[i]) begin
              k--;
              if (k == 0) begin
                off = i;
                break;
              end
            end
          end
          res.chosen_value = 16'(base + off);
          res.chosen_valid = 1'b1;
          present[off] = 1'b0;
          live--;
          if (pseudo > 0) pseudo--;
        end
      end
      MODE_REMOVE: begin
        // pseudo count drops whether or not the value is found
        if (pseudo > 0) pseudo--;
        if (it.remove_value >= base) begin
          off = int'(it.remove_value) - int'(base);
          if (off < CAP && present[off]) begin
            present[off] = 1'b0;
            live--;
          end
        end
      end
      MODE_REBUILD: begin
        n = (last_val >= first_val) ? int'(last_val) - int'(first_val) + 1 : 0;
        if (n > CAP) n = CAP;
        present = '0;
        for (int i = 0; i < n; i++) present[i] = 1'b1;
        base = first_val;
        live = n;
        pseudo = n;
        built = n;
      end
      default: ;
    endcase
    res.remaining_count = 13'(live);
    res.pseudo_count = 13'(pseudo);
    pending_results = {pending_results, res};
  endfunction

  function void report(string what, krsel_out_t want, krsel_out_t got);
    errors++;
    if (errors <= 10)
      $display("%0t %s: expected value %0d valid %0d remaining %0d pseudo %0d, got value %0d valid %0d remaining %0d pseudo %0d",
               $time, what, want.chosen_value, want.chosen_valid, want.remaining_count,
               want.pseudo_count, got.chosen_value, got.chosen_valid, got.remaining_count,
               got.pseudo_count);
  endfunction

  function void check_result(krsel_out_t got);
    krsel_out_t want;
    if (pending_results.size() == 0) begin
      report("unexpected result", '0, got);
      return;
    end
    want = pending_results.pop_front();
    if (got.chosen_value !== want.chosen_value || got.chosen_valid !== want.chosen_valid ||
        got.remaining_count !== want.remaining_count ||
        got.pseudo_count !== want.pseudo_count)
      report("result mismatch", want, got);
  endfunction
endclass

module testbench;
  localparam int CAPACITY = 4096;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  krsel_in_t   in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  krsel_out_t  out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  bit idle_on = 1'b0;
  int stall_left = 0;
  index_set_scoreboard #(CAPACITY) sb;

  always #6 clk = ~clk;

  kth_remaining_index_select_core #(
    .CAPACITY(CAPACITY)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // receiver back-pressure in random bursts
  always @(posedge clk) begin
    if (idle_on && stall_left == 0 && $urandom_range(0, 5) == 0)
      stall_left = $urandom_range(1, 9);
    if (idle_on && stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  function automatic krsel_in_t make_item(logic [1:0] m, logic [15:0] p, logic [15:0] r);
    krsel_in_t it;
    it.mode = m;
    it.position = p;
    it.remove_value = r;
    return it;
  endfunction

  // Mostly well-formed requests against the current set, the rest noise.
  function automatic krsel_in_t random_item();
    krsel_in_t it;
    int r;
    it.mode = MODE_UNUSED;
    it.position = 16'($urandom);
    it.remove_value = 16'($urandom);
    r = $urandom_range(0, 99);
    if (r < 45) begin
      it.mode = MODE_CHOOSE;
      if (sb.live > 0 && $urandom_range(0, 7) != 0) begin
        it.position = 16'($urandom_range(1, sb.live));
      end else begin
        case ($urandom_range(0, 3))
          0: it.position = '0;
          1: it.position = 16'(sb.live);
          2: it.position = 16'(sb.live + 1);
          default: ;
        endcase
      end
    end else if (r < 80) begin
      it.mode = MODE_REMOVE;
      if ($urandom_range(0, 7) != 0)
        it.remove_value = 16'(sb.base + $urandom_range(0, sb.built + 1));
      else if ($urandom_range(0, 1) == 0)
        it.remove_value = sb.base - 16'd1;
    end else if (r < 88) begin
      it.mode = MODE_REBUILD;
    end else if (r >= 94) begin
      it.mode = 2'($urandom);
    end
    return it;
  endfunction

  // Holds the transfer until accepted; may leave a gap after it.
  task automatic send_item(krsel_in_t it);
    int gap;
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_input(it);
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'h0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.write_reg(idx, v);
    @(posedge clk);
  endtask

  task automatic reconfigure(logic [15:0] lo, logic [15:0] hi);
    settle();
    write_reg(REG_FIRST, lo);
    write_reg(REG_LAST, hi);
  endtask

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

  initial begin
    logic [15:0] lo;
    logic [15:0] hi;
    int sel;
    int tmp;
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty set straight out of reset, pseudo count already at its floor
    send_item(make_item(MODE_CHOOSE, 16'd1, 16'($urandom)));
    send_item(make_item(MODE_REMOVE, 16'($urandom), 16'd0));
    send_item(make_item(MODE_UNUSED, 16'hFFFF, 16'hFFFF));
    send_item(make_item(MODE_REBUILD, 16'($urandom), 16'($urandom)));

    reconfigure(16'd100, 16'd110);
    send_item(make_item(MODE_REBUILD, 16'd0, 16'd0));
    send_item(make_item(MODE_CHOOSE, 16'd0, 16'($urandom)));
    send_item(make_item(MODE_CHOOSE, 16'd12, 16'($urandom)));
    send_item(make_item(MODE_CHOOSE, 16'd1, 16'($urandom)));
    send_item(make_item(MODE_CHOOSE, 16'd10, 16'($urandom)));
    send_item(make_item(MODE_REMOVE, 16'($urandom), 16'd105));
    send_item(make_item(MODE_REMOVE, 16'($urandom), 16'd105));
    send_item(make_item(MODE_REMOVE, 16'($urandom), 16'd99));
    send_item(make_item(MODE_REMOVE, 16'($urandom), 16'hFFFF));
    send_item(make_item(MODE_CHOOSE, 16'hFFFF, 16'($urandom)));

    // full window, clipped to capacity; last word is the slowest scan
    reconfigure(16'd0, 16'hFFFF);
    send_item(make_item(MODE_REBUILD, 16'($urandom), 16'($urandom)));
    send_item(make_item(MODE_CHOOSE, 16'd4096, 16'($urandom)));
    send_item(make_item(MODE_CHOOSE, 16'd1, 16'($urandom)));
    send_item(make_item(MODE_REMOVE, 16'($urandom), 16'd4095));
    send_item(make_item(MODE_REMOVE, 16'($urandom), 16'd4094));
    send_item(make_item(MODE_CHOOSE, 16'd4092, 16'($urandom)));

    reconfigure(16'hFFFF, 16'hFFFF);
    send_item(make_item(MODE_REBUILD, 16'($urandom), 16'($urandom)));
    send_item(make_item(MODE_CHOOSE, 16'd1, 16'($urandom)));
    send_item(make_item(MODE_REMOVE, 16'($urandom), 16'hFFFF));
    send_item(make_item(MODE_REMOVE, 16'($urandom), 16'd0));

    for (int ph = 0; ph < 20; ph++) begin
      case (ph)
        0: begin
          lo = 16'd0;
          hi = 16'hFFFF;
        end
        1: begin
          lo = 16'hFFFF;
          hi = 16'hFFFF;
        end
        2: begin
          lo = 16'd0;
          hi = 16'd0;
        end
        3: begin
          lo = 16'hFFFF;
          hi = 16'd0;
        end
        default: begin
          lo = 16'($urandom);
          sel = $urandom_range(0, 99);
          if (sel < 70) tmp = int'(lo) + $urandom_range(0, 300);
          else if (sel < 85) tmp = $urandom_range(0, 65535);
          else tmp = int'(lo) + $urandom_range(3900, 5000);
          hi = (tmp > 65535) ? 16'hFFFF : 16'(tmp);
        end
      endcase
      reconfigure(lo, hi);
      // no idling in the closing phases
      idle_on = (ph < 16) && ($urandom_range(0, 4) != 0);
      send_item(make_item(MODE_REBUILD, 16'($urandom), 16'($urandom)));
      repeat (99) send_item(random_item());
    end

    settle();
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/krsel_pkg.sv
rtl/krsel_bitmap_ram.sv
rtl/krsel_pop_unit.sv
rtl/krsel_seq.sv
rtl/kth_remaining_index_select_core.sv
dv/testbench.sv
